>>> src/looping_timeline_timer_macros.svh
// Assertion macros shared by the checker of the looping timeline timer.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef LOOPING_TIMELINE_TIMER_MACROS_SVH
`define LOOPING_TIMELINE_TIMER_MACROS_SVH

// An implication that must hold at every clock edge out of reset.
`define LTT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A result word that is held by stall must keep its value in the next cycle.
`define LTT_ASSERT_HOLD(label, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (result_valid && result_stall) |=> $stable(sig)) \
        else $error(msg);

`endif

>>> src/ltt_pkg.sv
// Shared types and codes of the looping timeline timer.
// Used by the configuration block, the core, the top level and the checker.
package ltt_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int PERIOD_W = 32;
    localparam int LIMIT_W = 16;
    localparam int FUNC_W = 3;
    localparam int EVENT_W = 3;
    localparam int STATE_W = 2;
    localparam int DIR_W = 2;

    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_LOOP_LIMIT = 2'd1;
    localparam logic [1:0] REG_LOOP_FOREVER = 2'd2;
    localparam logic [1:0] REG_DIRECTION = 2'd3;

    localparam logic [FUNC_W-1:0] FUNC_TICK = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PAUSE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RESUME = 3'd4;

    localparam logic [EVENT_W-1:0] EV_NONE = 3'd0;
    localparam logic [EVENT_W-1:0] EV_STARTED = 3'd1;
    localparam logic [EVENT_W-1:0] EV_STOPPED = 3'd2;
    localparam logic [EVENT_W-1:0] EV_PAUSED = 3'd3;
    localparam logic [EVENT_W-1:0] EV_RESUMED = 3'd4;
    localparam logic [EVENT_W-1:0] EV_FINISHED = 3'd5;
    localparam logic [EVENT_W-1:0] EV_RESTARTED = 3'd6;

    localparam logic [STATE_W-1:0] ST_STOPPED = 2'd0;
    localparam logic [STATE_W-1:0] ST_RUNNING = 2'd1;
    localparam logic [STATE_W-1:0] ST_PAUSED = 2'd2;

    localparam logic [DIR_W-1:0] DIR_BACKWARD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_ALTERNATE = 2'd2;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [LIMIT_W-1:0]  loop_limit;
        logic                loop_forever;
        logic [DIR_W-1:0]    direction_mode;
    } ltt_cfg_t;

    typedef struct packed {
        logic [EVENT_W-1:0]  event_code;
        logic                advanced;
        logic [PERIOD_W-1:0] applied_time;
        logic [PERIOD_W-1:0] position;
        logic [LIMIT_W-1:0]  loop_index;
        logic                reversed;
        logic [STATE_W-1:0]  run_state;
    } ltt_result_t;

endpackage

>>> src/looping_timeline_timer.sv
// Top level of the looping timeline timer: input register, core and result register.
// Depends on ltt_pkg, ltt_regs and ltt_core.
// The timer takes one word per clock: a tick with an elapsed time or a start, stop,
// pause or resume command, and gives exactly one result word for each, registered
// first in the input register and then in the result register. Throughput is one
// word per cycle while result_stall stays low; the position update is combinational:
// three compares, one subtract and one add. The user must write configuration
// through the APB port only while no word is in flight; the block does not enforce it.
module looping_timeline_timer
#(
    parameter int TIME_BITS = 32,
    parameter int LOOP_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ltt_pkg::ADDR_W-1:0]    paddr,
    input  logic [ltt_pkg::DATA_W-1:0]    pwdata,
    output logic [ltt_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [ltt_pkg::FUNC_W-1:0]    func,
    input  logic [ltt_pkg::PERIOD_W-1:0]  delta_time,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [ltt_pkg::EVENT_W-1:0]   event_code,
    output logic                          advanced,
    output logic [ltt_pkg::PERIOD_W-1:0]  applied_time,
    output logic [ltt_pkg::PERIOD_W-1:0]  position,
    output logic [ltt_pkg::LIMIT_W-1:0]   loop_index,
    output logic                          reversed,
    output logic [ltt_pkg::STATE_W-1:0]   run_state
);

    ltt_pkg::ltt_cfg_t            cfg;
    ltt_pkg::ltt_result_t         core_result;
    ltt_pkg::ltt_result_t         result_reg;
    logic                         in_valid_reg;
    logic [ltt_pkg::FUNC_W-1:0]   func_reg;
    logic [ltt_pkg::PERIOD_W-1:0] dt_reg;
    logic                         out_valid_reg;
    logic                         out_free;
    logic                         step_en;
    logic                         accept;

    assign out_free = !out_valid_reg || !result_stall;
    assign step_en = in_valid_reg && out_free;
    assign item_stall = in_valid_reg && !out_free;
    assign accept = item_valid && !item_stall;

    ltt_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ltt_core
    #(
        .TIME_BITS (TIME_BITS),
        .LOOP_BITS (LOOP_BITS)
    )
    u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .cfg        (cfg),
        .func       (func_reg),
        .delta_time (dt_reg),
        .result     (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step_en)
            begin
                in_valid_reg <= 1'b0;
            end
            if (step_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            dt_reg <= delta_time;
        end
        if (step_en)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign event_code = result_reg.event_code;
    assign advanced = result_reg.advanced;
    assign applied_time = result_reg.applied_time;
    assign position = result_reg.position;
    assign loop_index = result_reg.loop_index;
    assign reversed = result_reg.reversed;
    assign run_state = result_reg.run_state;

endmodule

>>> src/ltt_regs.sv
// Configuration registers of the looping timeline timer behind an APB-style port.
// Depends on ltt_pkg for the register indexes and the configuration struct.
module ltt_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ltt_pkg::ADDR_W-1:0]    paddr,
    input  logic [ltt_pkg::DATA_W-1:0]    pwdata,
    output logic [ltt_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output ltt_pkg::ltt_cfg_t             cfg
);

    ltt_pkg::ltt_cfg_t cfg_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period <= '0;
            cfg_reg.loop_limit <= ltt_pkg::LIMIT_W'(1);
            cfg_reg.loop_forever <= 1'b0;
            cfg_reg.direction_mode <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                ltt_pkg::REG_PERIOD:
                begin
                    cfg_reg.period <= pwdata[ltt_pkg::PERIOD_W-1:0];
                end
                ltt_pkg::REG_LOOP_LIMIT:
                begin
                    cfg_reg.loop_limit <= pwdata[ltt_pkg::LIMIT_W-1:0];
                end
                ltt_pkg::REG_LOOP_FOREVER:
                begin
                    cfg_reg.loop_forever <= pwdata[0];
                end
                ltt_pkg::REG_DIRECTION:
                begin
                    cfg_reg.direction_mode <= pwdata[ltt_pkg::DIR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            ltt_pkg::REG_PERIOD:       prdata = cfg_reg.period;
            ltt_pkg::REG_LOOP_LIMIT:   prdata = {16'b0, cfg_reg.loop_limit};
            ltt_pkg::REG_LOOP_FOREVER: prdata = {31'b0, cfg_reg.loop_forever};
            ltt_pkg::REG_DIRECTION:    prdata = {30'b0, cfg_reg.direction_mode};
            default:                   prdata = '0;
        endcase
    end

endmodule

>>> src/ltt_core.sv
// Timer state and the single-pass update logic for one command or tick word.
// Depends on ltt_pkg for codes, the configuration struct and the result struct.
module ltt_core
#(
    parameter int TIME_BITS = 32,
    parameter int LOOP_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  ltt_pkg::ltt_cfg_t             cfg,
    input  logic [ltt_pkg::FUNC_W-1:0]    func,
    input  logic [ltt_pkg::PERIOD_W-1:0]  delta_time,
    output ltt_pkg::ltt_result_t          result
);

    logic [ltt_pkg::STATE_W-1:0] run_mode_reg;
    logic [ltt_pkg::STATE_W-1:0] run_mode_next;
    logic [TIME_BITS-1:0]        time_pos_reg;
    logic [TIME_BITS-1:0]        time_pos_next;
    logic [LOOP_BITS-1:0]        loops_done_reg;
    logic [LOOP_BITS-1:0]        loops_done_next;
    logic                        alt_flip_reg;
    logic                        alt_flip_next;

    logic [TIME_BITS+31:0]       period_ext;
    logic [TIME_BITS+31:0]       dt_ext;
    logic [TIME_BITS-1:0]        per;
    logic [TIME_BITS-1:0]        dt;
    logic [TIME_BITS-1:0]        remain;
    logic [TIME_BITS-1:0]        step;
    logic [TIME_BITS-1:0]        pos_sum;
    logic                        wrap;
    logic [LOOP_BITS-1:0]        loops_inc;
    logic [ltt_pkg::LIMIT_W-1:0] limit;
    logic [LOOP_BITS+15:0]       loops_inc_ext;
    logic [LOOP_BITS+15:0]       limit_ext;
    logic                        more_loops;
    logic [ltt_pkg::EVENT_W-1:0] event_code;
    logic                        advanced;
    logic [TIME_BITS-1:0]        applied;
    logic [TIME_BITS+31:0]       applied_ext;
    logic [TIME_BITS+31:0]       pos_ext;
    logic [LOOP_BITS+15:0]       loops_ext;

    assign period_ext = {{TIME_BITS{1'b0}}, cfg.period};
    assign dt_ext = {{TIME_BITS{1'b0}}, delta_time};
    assign per = period_ext[TIME_BITS-1:0];
    assign dt = dt_ext[TIME_BITS-1:0];

    assign remain = (time_pos_reg < per) ? (per - time_pos_reg) : '0;
    assign step = (dt < remain) ? dt : remain;
    assign pos_sum = time_pos_reg + step;
    assign wrap = (pos_sum >= per);

    assign loops_inc = (&loops_done_reg) ? loops_done_reg : (loops_done_reg + 1'b1);
    assign limit = (cfg.loop_limit == '0) ? ltt_pkg::LIMIT_W'(1) : cfg.loop_limit;
    assign loops_inc_ext = {16'b0, loops_inc};
    assign limit_ext = {{LOOP_BITS{1'b0}}, limit};
    assign more_loops = cfg.loop_forever || (loops_inc_ext < limit_ext);

    always_comb
    begin
        run_mode_next = run_mode_reg;
        time_pos_next = time_pos_reg;
        loops_done_next = loops_done_reg;
        alt_flip_next = alt_flip_reg;
        event_code = ltt_pkg::EV_NONE;
        advanced = 1'b0;
        applied = '0;
        case (func)
            ltt_pkg::FUNC_TICK:
            begin
                if (run_mode_reg == ltt_pkg::ST_RUNNING)
                begin
                    advanced = 1'b1;
                    applied = step;
                    time_pos_next = pos_sum;
                    if (wrap)
                    begin
                        loops_done_next = loops_inc;
                        if (more_loops)
                        begin
                            if (cfg.direction_mode == ltt_pkg::DIR_ALTERNATE)
                            begin
                                alt_flip_next = !alt_flip_reg;
                            end
                            time_pos_next = '0;
                            event_code = ltt_pkg::EV_RESTARTED;
                        end
                        else
                        begin
                            run_mode_next = ltt_pkg::ST_STOPPED;
                            event_code = ltt_pkg::EV_FINISHED;
                        end
                    end
                end
            end
            ltt_pkg::FUNC_START:
            begin
                time_pos_next = '0;
                loops_done_next = '0;
                alt_flip_next = 1'b0;
                run_mode_next = ltt_pkg::ST_RUNNING;
                event_code = ltt_pkg::EV_STARTED;
            end
            ltt_pkg::FUNC_STOP:
            begin
                if (run_mode_reg != ltt_pkg::ST_STOPPED)
                begin
                    run_mode_next = ltt_pkg::ST_STOPPED;
                    time_pos_next = '0;
                    loops_done_next = '0;
                    event_code = ltt_pkg::EV_STOPPED;
                end
            end
            ltt_pkg::FUNC_PAUSE:
            begin
                if (run_mode_reg == ltt_pkg::ST_RUNNING)
                begin
                    run_mode_next = ltt_pkg::ST_PAUSED;
                    event_code = ltt_pkg::EV_PAUSED;
                end
            end
            ltt_pkg::FUNC_RESUME:
            begin
                if (run_mode_reg == ltt_pkg::ST_PAUSED)
                begin
                    run_mode_next = ltt_pkg::ST_RUNNING;
                    event_code = ltt_pkg::EV_RESUMED;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_mode_reg <= ltt_pkg::ST_STOPPED;
            time_pos_reg <= '0;
            loops_done_reg <= '0;
            alt_flip_reg <= 1'b0;
        end
        else if (step_en)
        begin
            run_mode_reg <= run_mode_next;
            time_pos_reg <= time_pos_next;
            loops_done_reg <= loops_done_next;
            alt_flip_reg <= alt_flip_next;
        end
    end

    assign applied_ext = {32'b0, applied};
    assign pos_ext = {32'b0, time_pos_next};
    assign loops_ext = {16'b0, loops_done_next};

    always_comb
    begin
        result.event_code = event_code;
        result.advanced = advanced;
        result.applied_time = applied_ext[ltt_pkg::PERIOD_W-1:0];
        result.position = pos_ext[ltt_pkg::PERIOD_W-1:0];
        result.loop_index = loops_ext[ltt_pkg::LIMIT_W-1:0];
        result.reversed = (cfg.direction_mode == ltt_pkg::DIR_BACKWARD)
            || ((cfg.direction_mode == ltt_pkg::DIR_ALTERNATE) && alt_flip_next);
        result.run_state = run_mode_next;
    end

endmodule

>>> src/ltt_checker.sv
// Port-level checker of the looping timeline timer, bound to the top level.
// Depends on ltt_pkg and the assertion macros in looping_timeline_timer_macros.svh.
`include "looping_timeline_timer_macros.svh"

module ltt_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic [ltt_pkg::EVENT_W-1:0]   event_code,
    input  logic                          advanced,
    input  logic [ltt_pkg::PERIOD_W-1:0]  applied_time,
    input  logic [ltt_pkg::PERIOD_W-1:0]  position,
    input  logic [ltt_pkg::LIMIT_W-1:0]   loop_index,
    input  logic [ltt_pkg::STATE_W-1:0]   run_state
);

    `LTT_ASSERT_HOLD(a_hold_position, position, "Held result word changed its position.")

    `LTT_ASSERT_IMPLY(a_idle_no_time, result_valid && !advanced, applied_time == '0, "Time applied without a running tick.")

    `LTT_ASSERT_IMPLY(a_start_clears, result_valid && event_code == ltt_pkg::EV_STARTED, position == '0 && loop_index == '0 && run_state == ltt_pkg::ST_RUNNING, "Start did not clear the timer.")

    `LTT_ASSERT_IMPLY(a_finish_stops, result_valid && event_code == ltt_pkg::EV_FINISHED, advanced && run_state == ltt_pkg::ST_STOPPED, "Finish did not stop the timer.")

    `LTT_ASSERT_IMPLY(a_restart_rewinds, result_valid && event_code == ltt_pkg::EV_RESTARTED, advanced && position == '0 && run_state == ltt_pkg::ST_RUNNING, "Loop restart left a position behind.")

endmodule

bind looping_timeline_timer ltt_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .event_code   (event_code),
    .advanced     (advanced),
    .applied_time (applied_time),
    .position     (position),
    .loop_index   (loop_index),
    .run_state    (run_state)
);

>>> test/tb_looping_timeline_timer.sv
`timescale 1ns / 100ps
// Self-checking testbench for looping_timeline_timer: directed and random word streams.
// Depends on ltt_pkg and the RTL of the timer; a scoreboard class predicts every result.
module tb_looping_timeline_timer;

    localparam logic [ltt_pkg::DIR_W-1:0] DIR_FORWARD = 2'd0;
    localparam logic [ltt_pkg::DIR_W-1:0] DIR_SPARE = 2'd3;
    localparam logic [ltt_pkg::FUNC_W-1:0] FUNC_TOP = '1;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES = 40;
    localparam int FOREVER_TICKS = 20;

    class timeline_scoreboard;
        ltt_pkg::ltt_cfg_t cfg;
        logic [ltt_pkg::STATE_W-1:0] run_mode;
        logic [ltt_pkg::PERIOD_W-1:0] time_pos;
        logic [ltt_pkg::LIMIT_W-1:0] loops_done;
        logic alt_flip;
        ltt_pkg::ltt_result_t due_results[$];
        int errors;
        int checked;

        function new();
            cfg.period = '0;
            cfg.loop_limit = 16'd1;
            cfg.loop_forever = 1'b0;
            cfg.direction_mode = DIR_FORWARD;
            run_mode = ltt_pkg::ST_STOPPED;
            time_pos = '0;
            loops_done = '0;
            alt_flip = 1'b0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [ltt_pkg::DATA_W-1:0] val);
            case (idx)
                ltt_pkg::REG_PERIOD: cfg.period = val;
                ltt_pkg::REG_LOOP_LIMIT: cfg.loop_limit = val[ltt_pkg::LIMIT_W-1:0];
                ltt_pkg::REG_LOOP_FOREVER: cfg.loop_forever = val[0];
                ltt_pkg::REG_DIRECTION: cfg.direction_mode = val[ltt_pkg::DIR_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [ltt_pkg::PERIOD_W-1:0] room();
            return (time_pos < cfg.period) ? cfg.period - time_pos : '0;
        endfunction

        function void predict_word(logic [ltt_pkg::FUNC_W-1:0] f,
                                   logic [ltt_pkg::PERIOD_W-1:0] dt);
            ltt_pkg::ltt_result_t r;
            logic [ltt_pkg::PERIOD_W-1:0] step;
            logic [ltt_pkg::LIMIT_W-1:0] goal;
            r = '0;
            r.event_code = ltt_pkg::EV_NONE;
            case (f)
                ltt_pkg::FUNC_TICK:
                    if (run_mode == ltt_pkg::ST_RUNNING)
                    begin
                        r.advanced = 1'b1;
                        step = (dt < room()) ? dt : room();
                        time_pos = time_pos + step;
                        r.applied_time = step;
                        if (time_pos >= cfg.period)
                        begin
                            if (loops_done != '1)
                                loops_done = loops_done + 1'b1;
                            goal = (cfg.loop_limit == '0) ? 16'd1 : cfg.loop_limit;
                            if (cfg.loop_forever || loops_done < goal)
                            begin
                                if (cfg.direction_mode == ltt_pkg::DIR_ALTERNATE)
                                    alt_flip = ~alt_flip;
                                time_pos = '0;
                                r.event_code = ltt_pkg::EV_RESTARTED;
                            end
                            else
                            begin
                                run_mode = ltt_pkg::ST_STOPPED;
                                r.event_code = ltt_pkg::EV_FINISHED;
                            end
                        end
                    end
                ltt_pkg::FUNC_START:
                begin
                    time_pos = '0;
                    loops_done = '0;
                    alt_flip = 1'b0;
                    run_mode = ltt_pkg::ST_RUNNING;
                    r.event_code = ltt_pkg::EV_STARTED;
                end
                ltt_pkg::FUNC_STOP:
                    if (run_mode != ltt_pkg::ST_STOPPED)
                    begin
                        run_mode = ltt_pkg::ST_STOPPED;
                        time_pos = '0;
                        loops_done = '0;
                        r.event_code = ltt_pkg::EV_STOPPED;
                    end
                ltt_pkg::FUNC_PAUSE:
                    if (run_mode == ltt_pkg::ST_RUNNING)
                    begin
                        run_mode = ltt_pkg::ST_PAUSED;
                        r.event_code = ltt_pkg::EV_PAUSED;
                    end
                ltt_pkg::FUNC_RESUME:
                    if (run_mode == ltt_pkg::ST_PAUSED)
                    begin
                        run_mode = ltt_pkg::ST_RUNNING;
                        r.event_code = ltt_pkg::EV_RESUMED;
                    end
                default: ;
            endcase
            r.position = time_pos;
            r.loop_index = loops_done;
            r.reversed = (cfg.direction_mode == ltt_pkg::DIR_BACKWARD) ||
                         (cfg.direction_mode == ltt_pkg::DIR_ALTERNATE && alt_flip);
            r.run_state = run_mode;
            due_results.push_back(r);
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(ltt_pkg::ltt_result_t got);
            ltt_pkg::ltt_result_t want;
            if (due_results.size() == 0)
            begin
                $error("result word arrived with no prediction pending");
                errors++;
                return;
            end
            want = due_results.pop_front();
            checked++;
            compare("event_code", want.event_code, got.event_code);
            compare("advanced", want.advanced, got.advanced);
            compare("applied_time", want.applied_time, got.applied_time);
            compare("position", want.position, got.position);
            compare("loop_index", want.loop_index, got.loop_index);
            compare("reversed", want.reversed, got.reversed);
            compare("run_state", want.run_state, got.run_state);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ltt_pkg::ADDR_W-1:0] paddr;
    logic [ltt_pkg::DATA_W-1:0] pwdata;
    logic [ltt_pkg::DATA_W-1:0] prdata;
    logic pready;
    logic item_valid;
    logic item_stall;
    logic [ltt_pkg::FUNC_W-1:0] func;
    logic [ltt_pkg::PERIOD_W-1:0] delta_time;
    logic result_valid;
    logic result_stall;
    logic [ltt_pkg::EVENT_W-1:0] event_code;
    logic advanced;
    logic [ltt_pkg::PERIOD_W-1:0] applied_time;
    logic [ltt_pkg::PERIOD_W-1:0] position;
    logic [ltt_pkg::LIMIT_W-1:0] loop_index;
    logic reversed;
    logic [ltt_pkg::STATE_W-1:0] run_state;

    timeline_scoreboard sb = new();
    bit idle_on = 1'b1;
    bit hold_request = 1'b0;
    int words_sent = 0;
    int settings_used = 0;
    int quiet_cycles = 0;

    looping_timeline_timer dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .func(func),
        .delta_time(delta_time),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .event_code(event_code),
        .advanced(advanced),
        .applied_time(applied_time),
        .position(position),
        .loop_index(loop_index),
        .reversed(reversed),
        .run_state(run_state)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic send_word(input logic [ltt_pkg::FUNC_W-1:0] f,
                             input logic [ltt_pkg::PERIOD_W-1:0] dt);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_valid <= 1'b1;
        func <= f;
        delta_time <= dt;
        do
            @(posedge clk);
        while (item_stall);
        sb.predict_word(f, dt);
        words_sent++;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [ltt_pkg::DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_config(input logic [ltt_pkg::PERIOD_W-1:0] per,
                              input logic [ltt_pkg::LIMIT_W-1:0] lim,
                              input logic forever_on,
                              input logic [ltt_pkg::DIR_W-1:0] dir);
        drain();
        cfg_write(ltt_pkg::REG_PERIOD, per);
        cfg_write(ltt_pkg::REG_LOOP_LIMIT, ltt_pkg::DATA_W'(lim));
        cfg_write(ltt_pkg::REG_LOOP_FOREVER, ltt_pkg::DATA_W'(forever_on));
        cfg_write(ltt_pkg::REG_DIRECTION, ltt_pkg::DATA_W'(dir));
        settings_used++;
    endtask

    task automatic random_words(input int count);
        logic [ltt_pkg::FUNC_W-1:0] f;
        logic [ltt_pkg::PERIOD_W-1:0] dt;
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (sb.run_mode == ltt_pkg::ST_STOPPED && $urandom_range(0, 2) != 0)
                f = ltt_pkg::FUNC_START;
            else if (pick < 70)
                f = ltt_pkg::FUNC_TICK;
            else if (pick < 77)
                f = ltt_pkg::FUNC_START;
            else if (pick < 84)
                f = ltt_pkg::FUNC_PAUSE;
            else if (pick < 91)
                f = ltt_pkg::FUNC_RESUME;
            else if (pick < 96)
                f = ltt_pkg::FUNC_STOP;
            else
                f = FUNC_TOP - ltt_pkg::FUNC_W'($urandom_range(0, 2));
            case ($urandom_range(0, 7))
                0: dt = '0;
                1: dt = '1;
                2: dt = sb.room();
                3: dt = sb.room() + 1'b1;
                4: dt = sb.room() - 1'b1;
                7: dt = $urandom();
                default: dt = $urandom_range(0, sb.cfg.period / 4 + 1);
            endcase
            send_word(f, dt);
        end
    endtask

    initial
    begin
        int burst;
        int hold_left;
        burst = 0;
        hold_left = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                sb.check_result({event_code, advanced, applied_time, position,
                                 loop_index, reversed, run_state});
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                result_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 3) - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_looping_timeline_timer failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_valid = 1'b0;
        func = ltt_pkg::FUNC_TICK;
        delta_time = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero period, so a running tick ends a loop at once.
        send_word(ltt_pkg::FUNC_TICK, '1);
        send_word(ltt_pkg::FUNC_STOP, '0);
        send_word(ltt_pkg::FUNC_PAUSE, '0);
        send_word(ltt_pkg::FUNC_RESUME, '0);
        send_word(ltt_pkg::FUNC_RESUME + 1'b1, '0);
        send_word(FUNC_TOP - 1'b1, '0);
        send_word(FUNC_TOP, '1);
        send_word(ltt_pkg::FUNC_START, '0);
        send_word(ltt_pkg::FUNC_TICK, '0);
        send_word(ltt_pkg::FUNC_START, '0);
        send_word(ltt_pkg::FUNC_PAUSE, '0);
        send_word(ltt_pkg::FUNC_TICK, 32'd5);
        send_word(ltt_pkg::FUNC_PAUSE, '0);
        send_word(ltt_pkg::FUNC_RESUME, '0);
        send_word(ltt_pkg::FUNC_RESUME, '0);
        send_word(ltt_pkg::FUNC_STOP, '0);
        send_word(ltt_pkg::FUNC_START, '0);

        set_config('1, '0, 1'b0, ltt_pkg::DIR_ALTERNATE);
        send_word(ltt_pkg::FUNC_TICK, '0);
        send_word(ltt_pkg::FUNC_TICK, 32'd1);
        send_word(ltt_pkg::FUNC_TICK, '1);
        send_word(ltt_pkg::FUNC_START, '0);
        send_word(ltt_pkg::FUNC_START, 32'h8000_0000);

        set_config(32'd5, 16'd2, 1'b0, DIR_SPARE);
        send_word(ltt_pkg::FUNC_START, '0);
        send_word(ltt_pkg::FUNC_TICK, 32'd5);
        send_word(ltt_pkg::FUNC_TICK, 32'd9);

        set_config(32'd10, 16'd3, 1'b0, DIR_FORWARD);
        random_words(110);
        set_config(32'd1, 16'd1, 1'b0, ltt_pkg::DIR_BACKWARD);
        random_words(50);
        hold_request = 1'b1;
        random_words(60);
        set_config('0, 16'd2, 1'b0, ltt_pkg::DIR_ALTERNATE);
        random_words(110);
        set_config('1, '1, 1'b0, ltt_pkg::DIR_ALTERNATE);
        random_words(110);
        set_config(ltt_pkg::PERIOD_W'($urandom_range(2, 40)), '0, 1'b0, DIR_SPARE);
        random_words(50);
        drain();
        random_words(60);
        set_config(ltt_pkg::PERIOD_W'($urandom_range(1, 100)),
                   ltt_pkg::LIMIT_W'($urandom_range(2, 6)), 1'b1, ltt_pkg::DIR_ALTERNATE);
        random_words(110);
        set_config(32'd7, '1, 1'b1, ltt_pkg::DIR_BACKWARD);
        random_words(110);
        set_config(ltt_pkg::PERIOD_W'($urandom()), ltt_pkg::LIMIT_W'($urandom()), 1'b0,
                   ltt_pkg::DIR_W'($urandom_range(0, 3)));
        random_words(110);
        set_config(32'd3, 16'd2, 1'b0, ltt_pkg::DIR_ALTERNATE);
        hold_request = 1'b1;
        random_words(110);

        // Run past the loop limit in endless mode, then let it finish on the next loop.
        idle_on = 1'b0;
        set_config('0, 16'd8, 1'b1, ltt_pkg::DIR_ALTERNATE);
        send_word(ltt_pkg::FUNC_START, '0);
        repeat (FOREVER_TICKS) send_word(ltt_pkg::FUNC_TICK, $urandom());
        drain();
        cfg_write(ltt_pkg::REG_LOOP_FOREVER, '0);
        send_word(ltt_pkg::FUNC_TICK, 32'd1);

        set_config(32'd50, 16'd4, 1'b1, DIR_FORWARD);
        random_words(110);

        drain();
        repeat (6) @(posedge clk);
        $display("Covered %0d words under %0d register settings; %0d results checked.",
                 words_sent, settings_used, sb.checked);
        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("tb_looping_timeline_timer passed");
        else
            $display("tb_looping_timeline_timer failed");
        $finish;
    end
endmodule
